// ===== sv/zcse_pkg.sv =====
`timescale 1ns / 1ps
// ============================================================================
// zcse_pkg
// Shared widths, codes and word types of the zero-crossing Strouhal estimator.
// ============================================================================
package zcse_pkg;

    // Field formats.
    localparam int TIME_W   = 32;               // sample time, unsigned, 16 fraction bits
    localparam int SAMPLE_W = 16;               // lift sample, signed
    localparam int COUNT_W  = 20;               // sample and crossing counts
    localparam int WORD_W   = 32;               // Q16.16 registers and the result
    localparam int TFRAC_W  = 16;               // fraction bits of the sample time

    // Derived datapath widths.
    localparam int CROSS_W   = TIME_W + 16;     // crossing time, 32 fraction bits
    localparam int FRAC_W    = 32;              // fraction bits of the interpolation factor
    localparam int F_W       = FRAC_W + 1;      // the factor itself reaches one
    localparam int SPAN_W    = 2 * WORD_W;      // span, padded to two multiplier passes
    localparam int MUL_A_W   = F_W;
    localparam int MUL_B_W   = WORD_W;
    localparam int PROD_W    = MUL_A_W + MUL_B_W;
    localparam int ND_W      = COUNT_W + WORD_W;
    localparam int NUM_SHIFT = 48;
    localparam int NUM_W     = ND_W + NUM_SHIFT;
    localparam int DEN_W     = WORD_W + SPAN_W;
    localparam int Q_W       = WORD_W;
    localparam int DSH_W     = DEN_W + Q_W - 1;
    localparam int SAT_W     = DEN_W + Q_W;
    localparam int STEPS_W   = $clog2((FRAC_W > Q_W) ? FRAC_W : Q_W);

    // Validity limits.
    localparam int MIN_SAMPLES   = 4;
    localparam int MIN_CROSSINGS = 2;

    // Register reset values.
    localparam logic [COUNT_W-1:0] RESET_SERIES_LEN = '0;
    localparam logic [WORD_W-1:0]  RESET_DIAMETER   = WORD_W'(65536);
    localparam logic [WORD_W-1:0]  RESET_SPEED      = WORD_W'(65536);

    // Configuration port.
    localparam int CFG_IDX_W = 2;
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SERIES_LEN        = 2'd0,
        CFG_BODY_DIAMETER     = 2'd1,
        CFG_FREE_STREAM_SPEED = 2'd2
    } t_cfg_idx;

    typedef struct packed {
        logic [COUNT_W-1:0] series_len;
        logic [WORD_W-1:0]  body_diameter;
        logic [WORD_W-1:0]  free_stream_speed;
    } t_cfg;

    // Channel words.
    typedef struct packed {
        logic [TIME_W-1:0]          sample_time;
        logic signed [SAMPLE_W-1:0] lift_sample;
    } t_in_item;

    typedef struct packed {
        logic [WORD_W-1:0]  strouhal;
        logic               result_valid;
        logic [COUNT_W-1:0] crossing_total;
    } t_out_item;

    // Operand selections of the shared multiplier.
    typedef enum logic [2:0] {
        MUL_OFS_HI,
        MUL_OFS_LO,
        MUL_ND,
        MUL_VS_LO,
        MUL_VS_HI
    } t_mul_op;

    typedef struct packed {
        logic    load;
        logic    div_start;
        logic    div_step;
        logic    mul_en;
        t_mul_op mul_op;
        logic    cross_rec;
        logic    update;
        logic    sdiv_init;
        logic    sdiv_step;
        logic    out_load;
    } t_cmd;

    typedef struct packed {
        logic zero_count;
        logic is_cross;
        logic is_last;
        logic fin_ok;
    } t_status;

endpackage

// ===== sv/zcse_datapath.sv =====
`timescale 1ns / 1ps
// ============================================================================
// zcse_datapath
// Series state, interpolation divider, shared multiplier, quotient unit and
// the result register of the Strouhal estimator.
// ============================================================================
module zcse_datapath
    import zcse_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cmd      i_cmd,
    input  t_in_item  i_in,
    input  t_cfg      i_cfg,
    output t_status   o_status,
    output t_out_item o_out
);

    // Current sample.
    logic [TIME_W-1:0]          r_cur_time;
    logic signed [SAMPLE_W-1:0] r_cur_lift;

    // Series state.
    logic [COUNT_W-1:0]         r_index;
    logic [TIME_W-1:0]          r_prev_time;
    logic signed [SAMPLE_W-1:0] r_prev_lift;
    logic [CROSS_W-1:0]         r_first;
    logic [CROSS_W-1:0]         r_last;
    logic [COUNT_W-1:0]         r_ccount;

    // Interpolation.
    logic [SAMPLE_W-1:0] r_dvs;
    logic [SAMPLE_W-1:0] r_drem;
    logic [F_W-1:0]      r_f;
    logic [TIME_W-1:0]   r_dt;
    logic                r_back;
    logic [CROSS_W-1:0]  r_ofs;

    // Strouhal quotient.
    logic [ND_W-1:0]  r_nd;
    logic [DEN_W-1:0] r_den;
    logic [NUM_W-1:0] r_srem;
    logic [DSH_W-1:0] r_dsh;
    logic [Q_W-1:0]   r_q;
    logic             r_sat;

    t_out_item r_out;

    // ------------------------------------------------------------------------
    // Decisions on the current sample.
    // ------------------------------------------------------------------------
    logic [COUNT_W-1:0] half_idx;
    logic [COUNT_W-1:0] last_idx;

    assign half_idx = (i_cfg.series_len >> 1) + COUNT_W'(1);
    assign last_idx = i_cfg.series_len - COUNT_W'(1);

    assign o_status.zero_count = (i_cfg.series_len == '0);
    assign o_status.is_last    = (r_index >= last_idx);
    assign o_status.is_cross   = (r_index >= half_idx) && r_prev_lift[SAMPLE_W-1]
                               && !r_cur_lift[SAMPLE_W-1];
    assign o_status.fin_ok     = (i_cfg.series_len >= COUNT_W'(MIN_SAMPLES))
                               && (r_ccount >= COUNT_W'(MIN_CROSSINGS))
                               && (i_cfg.free_stream_speed != '0)
                               && (r_last > r_first);

    // ------------------------------------------------------------------------
    // Interpolation divider: fraction = -prev * 2^32 / (cur - prev).
    // The dividend never exceeds the divisor, so the top quotient bit is a
    // single compare and the remaining bits take one step each.
    // ------------------------------------------------------------------------
    logic [SAMPLE_W-1:0] neg_prev;
    logic [SAMPLE_W:0]   lift_step;
    logic [SAMPLE_W-1:0] lift_div;
    logic                q_top;
    logic [SAMPLE_W:0]   rem_sh;
    logic [SAMPLE_W:0]   dvs_ext;
    logic                take_f;
    logic [SAMPLE_W:0]   rem_nx;
    logic                t_fwd;

    assign neg_prev  = SAMPLE_W'(~r_prev_lift) + SAMPLE_W'(1'b1);
    assign lift_step = {r_cur_lift[SAMPLE_W-1], r_cur_lift}
                     - {r_prev_lift[SAMPLE_W-1], r_prev_lift};
    assign lift_div  = lift_step[SAMPLE_W-1:0];
    assign q_top     = (neg_prev >= lift_div);
    assign rem_sh    = {r_drem, 1'b0};
    assign dvs_ext   = {1'b0, r_dvs};
    assign take_f    = (rem_sh >= dvs_ext);
    assign rem_nx    = take_f ? (rem_sh - dvs_ext) : rem_sh;
    assign t_fwd     = (r_cur_time >= r_prev_time);

    // ------------------------------------------------------------------------
    // Shared multiplier.
    // ------------------------------------------------------------------------
    logic [MUL_A_W-1:0] mul_a;
    logic [MUL_B_W-1:0] mul_b;
    logic [PROD_W-1:0]  prod;
    logic [SPAN_W-1:0]  span;
    logic [COUNT_W-1:0] cc_m1;

    assign span  = SPAN_W'(r_last - r_first);
    assign cc_m1 = r_ccount - COUNT_W'(1);

    always_comb begin
        unique case (i_cmd.mul_op)
            MUL_OFS_HI: begin
                mul_a = r_f;
                mul_b = MUL_B_W'(r_dt >> TFRAC_W);
            end
            MUL_OFS_LO: begin
                mul_a = r_f;
                mul_b = MUL_B_W'(r_dt[TFRAC_W-1:0]);
            end
            MUL_ND: begin
                mul_a = MUL_A_W'(cc_m1);
                mul_b = i_cfg.body_diameter;
            end
            MUL_VS_LO: begin
                mul_a = MUL_A_W'(i_cfg.free_stream_speed);
                mul_b = span[WORD_W-1:0];
            end
            MUL_VS_HI: begin
                mul_a = MUL_A_W'(i_cfg.free_stream_speed);
                mul_b = span[SPAN_W-1:WORD_W];
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod = mul_a * mul_b;

    // ------------------------------------------------------------------------
    // Crossing time and quotient step.
    // ------------------------------------------------------------------------
    logic [CROSS_W-1:0] base;
    logic [CROSS_W-1:0] cross_time;
    logic [NUM_W-1:0]   num;
    logic [SAT_W-1:0]   den_top;
    logic [DSH_W-1:0]   srem_ext;
    logic               take_q;
    logic [DSH_W-1:0]   srem_nx;

    assign base       = {r_prev_time, {TFRAC_W{1'b0}}};
    assign cross_time = r_back ? (base - r_ofs) : (base + r_ofs);
    assign num        = {r_nd, {NUM_SHIFT{1'b0}}};
    assign den_top    = {r_den, {Q_W{1'b0}}};
    assign srem_ext   = DSH_W'(r_srem);
    assign take_q     = (srem_ext >= r_dsh);
    assign srem_nx    = take_q ? (srem_ext - r_dsh) : srem_ext;

    // Series state, cleared by reset and at the end of each series.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_index     <= '0;
            r_prev_time <= '0;
            r_prev_lift <= '0;
            r_first     <= '0;
            r_last      <= '0;
            r_ccount    <= '0;
        end else begin
            if (i_cmd.cross_rec) begin
                if (r_ccount == '0) begin
                    r_first <= cross_time;
                end
                r_last <= cross_time;
                if (r_ccount != {COUNT_W{1'b1}}) begin
                    r_ccount <= r_ccount + COUNT_W'(1);
                end
            end
            if (i_cmd.update) begin
                r_prev_time <= r_cur_time;
                r_prev_lift <= r_cur_lift;
                if (!o_status.is_last) begin
                    r_index <= r_index + COUNT_W'(1);
                end
            end
            if (i_cmd.out_load) begin
                r_index     <= '0;
                r_prev_time <= '0;
                r_prev_lift <= '0;
                r_first     <= '0;
                r_last      <= '0;
                r_ccount    <= '0;
            end
        end
    end

    // Working registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_cur_time <= i_in.sample_time;
            r_cur_lift <= i_in.lift_sample;
        end
        if (i_cmd.div_start) begin
            r_dvs  <= lift_div;
            r_drem <= q_top ? (neg_prev - lift_div) : neg_prev;
            r_f    <= {{(F_W-1){1'b0}}, q_top};
            r_dt   <= t_fwd ? (r_cur_time - r_prev_time) : (r_prev_time - r_cur_time);
            r_back <= !t_fwd;
        end
        if (i_cmd.div_step) begin
            r_drem <= rem_nx[SAMPLE_W-1:0];
            r_f    <= {r_f[F_W-2:0], take_f};
        end
        if (i_cmd.mul_en) begin
            unique case (i_cmd.mul_op)
                MUL_OFS_HI: r_ofs <= CROSS_W'(prod);
                MUL_OFS_LO: r_ofs <= r_ofs + CROSS_W'(prod >> TFRAC_W);
                MUL_ND:     r_nd  <= ND_W'(prod);
                MUL_VS_LO:  r_den <= DEN_W'(prod);
                MUL_VS_HI:  r_den <= r_den + (DEN_W'(prod) << WORD_W);
                default:    r_den <= r_den;
            endcase
        end
        if (i_cmd.sdiv_init) begin
            r_sat  <= (SAT_W'(num) >= den_top);
            r_srem <= num;
            r_dsh  <= {r_den, {(Q_W-1){1'b0}}};
        end
        if (i_cmd.sdiv_step) begin
            r_srem <= NUM_W'(srem_nx);
            r_dsh  <= r_dsh >> 1;
            r_q    <= {r_q[Q_W-2:0], take_q};
        end
        if (i_cmd.out_load) begin
            r_out.strouhal       <= o_status.fin_ok ? (r_sat ? {WORD_W{1'b1}} : r_q) : '0;
            r_out.result_valid   <= o_status.fin_ok;
            r_out.crossing_total <= r_ccount;
        end
    end

    assign o_out = r_out;

    // ------------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------------
    a_div_rem_below: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.div_step |-> (r_drem < r_dvs))
        else $error("interpolation remainder not below divisor");

    a_cross_counted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.cross_rec |=> (r_ccount != '0))
        else $error("crossing recorded but count is zero");

    a_series_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.out_load |=> ((r_index == '0) && (r_ccount == '0)))
        else $error("series not cleared after result");

endmodule

// ===== sv/zcse_ctrl.sv =====
`timescale 1ns / 1ps
// ============================================================================
// zcse_ctrl
// Sequencer of the Strouhal estimator: steps the datapath through one sample
// and owns the input stall and the output valid flag.
// ============================================================================
module zcse_ctrl
    import zcse_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    input  logic    i_out_stall,
    input  t_status i_status,
    output t_cmd    o_cmd,
    output logic    o_in_stall,
    output logic    o_out_valid
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_EVAL,
        S_IDIV,
        S_MUL_HI,
        S_MUL_LO,
        S_CROSS,
        S_UPDATE,
        S_ND,
        S_VS_LO,
        S_VS_HI,
        S_SAT,
        S_SDIV,
        S_FIN
    } t_state;

    t_state             r_state;
    logic [STEPS_W-1:0] r_cnt;
    logic               r_out_valid;
    logic               slot_free;

    assign slot_free = !(r_out_valid && i_out_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // A new word may replace one that leaves on the same edge.
            if ((r_state == S_FIN) && slot_free) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_state <= S_EVAL;
                    end
                end
                S_EVAL: begin
                    priority if (i_status.zero_count) begin
                        r_state <= S_IDLE;
                    end else if (i_status.is_cross) begin
                        r_cnt   <= '0;
                        r_state <= S_IDIV;
                    end else begin
                        r_state <= S_UPDATE;
                    end
                end
                S_IDIV: begin
                    r_cnt <= r_cnt + STEPS_W'(1);
                    if (r_cnt == STEPS_W'(FRAC_W - 1)) begin
                        r_state <= S_MUL_HI;
                    end
                end
                S_MUL_HI: r_state <= S_MUL_LO;
                S_MUL_LO: r_state <= S_CROSS;
                S_CROSS:  r_state <= S_UPDATE;
                S_UPDATE: begin
                    priority if (!i_status.is_last) begin
                        r_state <= S_IDLE;
                    end else if (i_status.fin_ok) begin
                        r_state <= S_ND;
                    end else begin
                        r_state <= S_FIN;
                    end
                end
                S_ND:    r_state <= S_VS_LO;
                S_VS_LO: r_state <= S_VS_HI;
                S_VS_HI: r_state <= S_SAT;
                S_SAT: begin
                    r_cnt   <= '0;
                    r_state <= S_SDIV;
                end
                S_SDIV: begin
                    r_cnt <= r_cnt + STEPS_W'(1);
                    if (r_cnt == STEPS_W'(Q_W - 1)) begin
                        r_state <= S_FIN;
                    end
                end
                S_FIN: begin
                    if (slot_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_comb begin
        o_cmd           = '0;
        o_cmd.mul_op    = MUL_OFS_HI;
        o_cmd.load      = (r_state == S_IDLE) && i_in_valid;
        o_cmd.div_start = (r_state == S_EVAL) && !i_status.zero_count && i_status.is_cross;
        o_cmd.div_step  = (r_state == S_IDIV);
        o_cmd.cross_rec = (r_state == S_CROSS);
        o_cmd.update    = (r_state == S_UPDATE);
        o_cmd.sdiv_init = (r_state == S_SAT);
        o_cmd.sdiv_step = (r_state == S_SDIV);
        o_cmd.out_load  = (r_state == S_FIN) && slot_free;
        unique case (r_state)
            S_MUL_HI: begin
                o_cmd.mul_en = 1'b1;
                o_cmd.mul_op = MUL_OFS_HI;
            end
            S_MUL_LO: begin
                o_cmd.mul_en = 1'b1;
                o_cmd.mul_op = MUL_OFS_LO;
            end
            S_ND: begin
                o_cmd.mul_en = 1'b1;
                o_cmd.mul_op = MUL_ND;
            end
            S_VS_LO: begin
                o_cmd.mul_en = 1'b1;
                o_cmd.mul_op = MUL_VS_LO;
            end
            S_VS_HI: begin
                o_cmd.mul_en = 1'b1;
                o_cmd.mul_op = MUL_VS_HI;
            end
            default: o_cmd.mul_en = 1'b0;
        endcase
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;

    // ------------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------------
    a_valid_from_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> ($past(r_state) == S_FIN))
        else $error("output valid raised outside the finish state");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_FIN) && r_out_valid && i_out_stall) |=> (r_state == S_FIN))
        else $error("pending result word would be overwritten");

    a_div_only_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.sdiv_init |-> i_status.fin_ok)
        else $error("quotient started for an invalid result");

endmodule

// ===== sv/zero_crossing_strouhal_estimator_top.sv =====
`timescale 1ns / 1ps
// ============================================================================
// zero_crossing_strouhal_estimator_top
// Estimates the Strouhal number from the rising zero crossings of a lift
// series, with interpolated crossing times, in Q16.16 fixed point.
// ============================================================================
//
//  Channel   Direction  Handshake                  Word
//  --------  ---------  -------------------------  ------------------------------
//  input     in         i_in_valid / o_in_stall    sample_time, lift_sample
//  output    out        o_out_valid / i_out_stall  strouhal, result_valid,
//                                                  crossing_total
//  config    in         i_cfg_valid / o_cfg_ready  i_cfg_index, i_cfg_data
//
//  An ordinary sample passes through accept, evaluate and update. A sample that
//  completes a rising crossing also runs the 32-step interpolation divider and
//  two passes of the shared multiplier. The last sample of a series then adds
//  three multiplier passes, a saturation check and the 32-step quotient unit
//  for a valid estimate, or only the finish step for an invalid one, plus any
//  wait for the output word to drain.
//  Reset is synchronous and active low; it restores the register defaults and
//  clears the series. The output register holds one finished word, so further
//  samples are accepted while it waits under i_out_stall.
//
module zero_crossing_strouhal_estimator_top
    import zcse_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // Sample input.
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  t_in_item             i_in_data,
    // Result output.
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output t_out_item            o_out_data,
    // Register writes.
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [WORD_W-1:0]    i_cfg_data
);

    // ------------------------------------------------------------------------
    // Configuration registers. Writes are always taken; an index beyond the
    // register list is accepted and has no effect. A write during a series
    // does not restart it.
    // ------------------------------------------------------------------------
    logic [COUNT_W-1:0] r_series_len;
    logic [WORD_W-1:0]  r_body_diameter;
    logic [WORD_W-1:0]  r_free_stream_speed;
    t_cfg               cfg;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_series_len        <= RESET_SERIES_LEN;
            r_body_diameter     <= RESET_DIAMETER;
            r_free_stream_speed <= RESET_SPEED;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_SERIES_LEN:        r_series_len        <= i_cfg_data[COUNT_W-1:0];
                CFG_BODY_DIAMETER:     r_body_diameter     <= i_cfg_data;
                CFG_FREE_STREAM_SPEED: r_free_stream_speed <= i_cfg_data;
                default:               r_series_len        <= r_series_len;
            endcase
        end
    end

    assign cfg.series_len        = r_series_len;
    assign cfg.body_diameter     = r_body_diameter;
    assign cfg.free_stream_speed = r_free_stream_speed;

    // ------------------------------------------------------------------------
    // The sequencer issues one command set per cycle and the datapath reports
    // back the decisions that steer it: whether the sample closes a crossing,
    // whether it ends the series and whether the estimate will be valid.
    // ------------------------------------------------------------------------
    t_cmd    cmd;
    t_status status;

    zcse_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_out_stall (i_out_stall),
        .i_status    (status),
        .o_cmd       (cmd),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid)
    );

    // The datapath keeps the series state, the two dividers, the one shared
    // multiplier and the registered result word.
    zcse_datapath u_datapath (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (cmd),
        .i_in     (i_in_data),
        .i_cfg    (cfg),
        .o_status (status),
        .o_out    (o_out_data)
    );

endmodule

// ===== tb/zcse_estimate_checker.sv =====
`timescale 1ns / 1ps
// ============================================================================
// zcse_estimate_checker
// Watches the sample, result and register channels of the zero-crossing
// Strouhal estimator, predicts each result word and compares it field by field.
// ============================================================================
module zcse_estimate_checker
    import zcse_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  logic                 i_in_stall,
    input  t_in_item             i_in_data,
    input  logic                 i_out_valid,
    input  logic                 i_out_stall,
    input  t_out_item            i_out_data,
    input  logic                 i_cfg_valid,
    input  logic                 i_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [WORD_W-1:0]    i_cfg_data,
    output int                   o_mismatch_count,
    output int                   o_estimates_due
);

    localparam int STROUHAL_SHIFT = 48;

    // Register copies.
    logic [COUNT_W-1:0] cfg_samples;
    logic [WORD_W-1:0]  cfg_diam;
    logic [WORD_W-1:0]  cfg_speed;

    // Series state.
    logic [COUNT_W-1:0]         idx;
    logic [TIME_W-1:0]          prev_t;
    logic signed [SAMPLE_W-1:0] prev_lift;
    logic [CROSS_W-1:0]         first_x;
    logic [CROSS_W-1:0]         last_x;
    logic [COUNT_W-1:0]         n_cross;

    t_out_item estimates_due_q[$];
    t_out_item want;
    int        mismatch_total = 0;

    assign o_mismatch_count = mismatch_total;

    task automatic flag_mismatch(input string what, input logic [WORD_W-1:0] got,
                                 input logic [WORD_W-1:0] exp_val);
        begin
            $display("%0t mismatch: %s got %0h want %0h", $time, what, got, exp_val);
            mismatch_total++;
        end
    endtask

    task automatic clear_series();
        begin
            idx       = '0;
            prev_t    = '0;
            prev_lift = '0;
            first_x   = '0;
            last_x    = '0;
            n_cross   = '0;
        end
    endtask

    // Takes one sample into the series and queues the estimate when the series
    // closes on it.
    task automatic advance_series(input t_in_item w);
        longint       prev_v;
        longint       cur_v;
        logic [63:0]  frac;
        logic [63:0]  step;
        logic [63:0]  ofs;
        logic [63:0]  xing;
        logic [127:0] numer;
        logic [127:0] denom;
        logic [127:0] quot;
        t_out_item    est;
        begin
            prev_v = longint'(prev_lift);
            cur_v  = longint'($signed(w.lift_sample));
            if (cfg_samples != '0) begin
                if (32'(idx) >= 32'(cfg_samples >> 1) + 1 && prev_v < 0 && cur_v >= 0) begin
                    // Fraction of the step at which the line through the two
                    // samples meets zero, with 32 fraction bits.
                    frac = (64'(-prev_v) << 32) / 64'(cur_v - prev_v);
                    step = (w.sample_time >= prev_t) ? 64'(w.sample_time - prev_t)
                                                     : 64'(prev_t - w.sample_time);
                    ofs  = (step >> 16) * frac + (((step & 64'hFFFF) * frac) >> 16);
                    xing = 64'(prev_t) << (CROSS_W - TIME_W);
                    xing = (w.sample_time >= prev_t) ? xing + ofs : xing - ofs;
                    if (n_cross == '0) first_x = CROSS_W'(xing);
                    last_x = CROSS_W'(xing);
                    if (n_cross != '1) n_cross = n_cross + 1'b1;
                end
                prev_t    = w.sample_time;
                prev_lift = w.lift_sample;
                if (idx < cfg_samples - 1'b1) begin
                    idx = idx + 1'b1;
                end else begin
                    est.crossing_total = n_cross;
                    if (cfg_samples >= MIN_SAMPLES && n_cross >= MIN_CROSSINGS &&
                        cfg_speed != '0 && last_x > first_x) begin
                        numer = 128'(n_cross - 1'b1) * 128'(cfg_diam);
                        numer = numer << STROUHAL_SHIFT;
                        denom = 128'(cfg_speed) * 128'(last_x - first_x);
                        quot  = numer / denom;
                        est.strouhal     = ((quot >> WORD_W) != 0) ? '1 : quot[WORD_W-1:0];
                        est.result_valid = 1'b1;
                    end else begin
                        est.strouhal     = '0;
                        est.result_valid = 1'b0;
                    end
                    estimates_due_q.insert(estimates_due_q.size(), est);
                    clear_series();
                end
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cfg_samples = RESET_SERIES_LEN;
            cfg_diam    = RESET_DIAMETER;
            cfg_speed   = RESET_SPEED;
            clear_series();
            estimates_due_q.delete();
        end else begin
            // A result can never leave on the edge that takes its own sample,
            // so comparing before predicting is safe.
            if (i_out_valid && !i_out_stall) begin
                if (estimates_due_q.size() == 0) begin
                    flag_mismatch("result word with no estimate due", '0, '0);
                end else begin
                    want = estimates_due_q.pop_front();
                    if (i_out_data.strouhal != want.strouhal)
                        flag_mismatch("strouhal", i_out_data.strouhal, want.strouhal);
                    if (i_out_data.result_valid != want.result_valid)
                        flag_mismatch("result_valid", WORD_W'(i_out_data.result_valid),
                                      WORD_W'(want.result_valid));
                    if (i_out_data.crossing_total != want.crossing_total)
                        flag_mismatch("crossing_total", WORD_W'(i_out_data.crossing_total),
                                      WORD_W'(want.crossing_total));
                end
            end
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_SERIES_LEN:        cfg_samples = i_cfg_data[COUNT_W-1:0];
                    CFG_BODY_DIAMETER:     cfg_diam    = i_cfg_data;
                    CFG_FREE_STREAM_SPEED: cfg_speed   = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_in_valid && !i_in_stall) advance_series(i_in_data);
        end
        o_estimates_due <= estimates_due_q.size();
    end

endmodule

// ===== tb/zero_crossing_strouhal_estimator_top_tb.sv =====
`timescale 1ns / 1ps
// ============================================================================
// zero_crossing_strouhal_estimator_top_tb
// Drives lift series through the Strouhal estimator under several register
// settings and handshake pressures; a separate checker predicts every result.
// ============================================================================
module zero_crossing_strouhal_estimator_top_tb;
    import zcse_pkg::*;

    // Timing of the run. The longest quiet stretch of a correct run is the
    // receiver hold-off plus one slow series end plus the settling pause, so
    // the watchdog limit leaves a wide margin.
    localparam int RESET_CYCLES   = 10;
    localparam int SETTLE_CYCLES  = 200;
    localparam int HOLDOFF_CYCLES = 600;
    localparam int QUIET_LIMIT    = 5000;
    localparam int PHASE_COUNT    = 10;
    localparam int PHASE_SAMPLES  = 100;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    // Sample channel.
    logic      in_valid = 1'b0;
    logic      in_stall;
    t_in_item  in_data  = '0;

    // Result channel.
    logic      out_valid;
    logic      out_stall = 1'b0;
    t_out_item out_data;

    // Register write channel.
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [WORD_W-1:0]    cfg_data  = '0;

    int mismatches;
    int estimates_due;

    // Idling percentages of the two sides. The sender's is only touched by
    // the stimulus process; the receiver's is handed over by nonblocking
    // assignment so that the receiver process reads a settled value.
    int tx_idle_pct = 0;
    int rx_idle_pct = 0;

    // The stimulus asks for a hold-off by bumping its request count; the
    // receiver process serves each request and counts the stretch itself.
    int holdoff_reqs   = 0;
    int holdoffs_served = 0;
    int holdoff_left   = 0;

    int quiet_cycles = 0;

    always #4 clk = ~clk;

    zero_crossing_strouhal_estimator_top u_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    zcse_estimate_checker u_checker (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_in_valid       (in_valid),
        .i_in_stall       (in_stall),
        .i_in_data        (in_data),
        .i_out_valid      (out_valid),
        .i_out_stall      (out_stall),
        .i_out_data       (out_data),
        .i_cfg_valid      (cfg_valid),
        .i_cfg_ready      (cfg_ready),
        .i_cfg_index      (cfg_index),
        .i_cfg_data       (cfg_data),
        .o_mismatch_count (mismatches),
        .o_estimates_due  (estimates_due)
    );

    // Receiver: either serving a hold-off, in which case stall stays high for
    // the whole stretch, or stalling at random at the current percentage.
    always @(posedge clk) begin
        if (!rst_n) begin
            out_stall    <= 1'b0;
            holdoff_left <= 0;
        end else if (holdoff_left != 0) begin
            out_stall    <= 1'b1;
            holdoff_left <= holdoff_left - 1;
        end else if (holdoff_reqs != holdoffs_served) begin
            out_stall       <= 1'b1;
            holdoff_left    <= HOLDOFF_CYCLES - 1;
            holdoffs_served <= holdoffs_served + 1;
        end else begin
            out_stall <= ($urandom_range(0, 99) < rx_idle_pct);
        end
    end

    // Watchdog: counts cycles in which no word moves on any channel. A hung
    // block or a lost handshake ends the run here.
    always @(posedge clk) begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
            (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("status: fail");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Writes one register. Only called while the block has nothing in hand.
    task automatic write_reg(input t_cfg_idx which, input logic [WORD_W-1:0] value);
        begin
            cfg_valid <= 1'b1;
            cfg_index <= which;
            cfg_data  <= value;
            do @(posedge clk); while (!cfg_ready);
            cfg_valid <= 1'b0;
            @(posedge clk);
        end
    endtask

    // Offers one sample word, after the sender's random idle cycles, and
    // returns on the edge at which the block takes it. When no idle cycle is
    // drawn, valid simply stays high into the next word.
    task automatic offer_sample(input logic [TIME_W-1:0] t, input logic [SAMPLE_W-1:0] l);
        begin
            while ($urandom_range(0, 99) < tx_idle_pct) begin
                in_valid <= 1'b0;
                @(posedge clk);
            end
            in_valid <= 1'b1;
            in_data  <= '{sample_time: t, lift_sample: l};
            do @(posedge clk); while (in_stall);
        end
    endtask

    // The sender stops until every estimate due has arrived, then allows for
    // a sample still being worked on that produces no word of its own.
    task automatic drain();
        begin
            in_valid <= 1'b0;
            @(posedge clk);
            while (estimates_due != 0) @(posedge clk);
            repeat (SETTLE_CYCLES) @(posedge clk);
        end
    endtask

    // One series of samples. Well-formed series have rising time and a lift
    // that swings between runs of negative and non-negative values, so that
    // crossings land in the analysed half; noisy ones are random throughout.
    task automatic run_series(input int unsigned len, input bit noisy);
        logic [TIME_W-1:0]          t;
        logic signed [SAMPLE_W-1:0] l;
        int unsigned                step_max;
        int unsigned                run_left;
        int unsigned                mag;
        bit                         below;
        begin
            t        = $urandom;
            step_max = 1 << (4 * $urandom_range(0, 5));
            below    = 1'($urandom_range(0, 1));
            run_left = $urandom_range(1, 3);
            for (int k = 0; k < len; k++) begin
                if (noisy) begin
                    t = $urandom;
                    l = SAMPLE_W'($urandom);
                end else begin
                    // A zero step now and then gives an empty span.
                    t   = t + $urandom_range(0, step_max);
                    mag = $urandom_range(0, 32767) >> $urandom_range(0, 14);
                    l   = below ? SAMPLE_W'(-int'(mag) - 1) : SAMPLE_W'(mag);
                    run_left--;
                    if (run_left == 0) begin
                        below    = !below;
                        run_left = $urandom_range(1, 3);
                    end
                end
                offer_sample(t, l);
            end
        end
    endtask

    initial begin
        int unsigned n_samples;
        logic [WORD_W-1:0] diam;
        logic [WORD_W-1:0] speed;

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // ---------------- Directed part ----------------
        // The sample count comes out of reset at zero, so these two words at
        // the extremes of both fields must be swallowed without a result.
        offer_sample(32'h0000_0000, 16'sh8000);
        offer_sample(32'hFFFF_FFFF, 16'sh7FFF);
        drain();

        // The shortest series that is allowed to be valid. Only its last
        // sample lies in the analysed window, so at most one crossing is
        // found and the estimate is flagged invalid. The crossing spans the
        // full range of lift and most of the range of time.
        write_reg(CFG_SERIES_LEN, WORD_W'(4));
        write_reg(CFG_BODY_DIAMETER, WORD_W'(65536));
        write_reg(CFG_FREE_STREAM_SPEED, WORD_W'(65536));
        offer_sample(32'h0000_0000, -16'sd1);
        offer_sample(32'h0001_0000, 16'sd5);
        offer_sample(32'h0002_0000, 16'sh8000);
        offer_sample(32'hFFFF_FFFF, 16'sh7FFF);
        drain();

        // Two crossings that both end exactly on zero, with the largest
        // diameter over the smallest speed, so the estimate saturates.
        write_reg(CFG_SERIES_LEN, WORD_W'(8));
        write_reg(CFG_BODY_DIAMETER, '1);
        write_reg(CFG_FREE_STREAM_SPEED, WORD_W'(1));
        offer_sample(32'h0000_0100, 16'sd100);
        offer_sample(32'h0000_8100, -16'sd100);
        offer_sample(32'h0001_0100, 16'sd200);
        offer_sample(32'h0001_8100, -16'sd300);
        offer_sample(32'h0002_0100, -16'sd7);
        offer_sample(32'h0002_8100, 16'sd0);
        offer_sample(32'h0003_0100, 16'sh8000);
        offer_sample(32'h0003_8100, 16'sd0);
        drain();

        // A series started under the largest count, then the count is
        // lowered below the current index: the next sample closes the series.
        // Time runs backwards through the crossing it completes.
        write_reg(CFG_SERIES_LEN, WORD_W'(20'hFFFFF));
        offer_sample(32'h0003_0000, 16'sd10);
        offer_sample(32'h0002_8000, -16'sd20);
        offer_sample(32'h0002_0000, -16'sd4096);
        drain();
        write_reg(CFG_SERIES_LEN, WORD_W'(2));
        offer_sample(32'h0001_8000, 16'sd4096);
        drain();

        // ---------------- Random part ----------------
        // Each phase writes all three registers while the block is idle,
        // then runs whole series. The first third idles the sender lightly
        // and the receiver heavily, the second the other way round, the last
        // neither. Series lengths stay small so that results come often.
        for (int p = 0; p < PHASE_COUNT; p++) begin
            case (p)
                0: begin n_samples = 8;  diam = 32'd65536;  speed = 32'd65536; end
                1: begin
                    n_samples = 12;
                    diam      = $urandom_range(1 << 14, 1 << 18);
                    speed     = $urandom_range(1 << 14, 1 << 18);
                end
                2: begin n_samples = 5;  diam = '0;        speed = $urandom; end
                3: begin n_samples = 16; diam = '1;        speed = 32'd1; end
                4: begin n_samples = 9;  diam = $urandom;  speed = '0; end
                5: begin n_samples = 1;  diam = $urandom;  speed = $urandom; end
                6: begin
                    n_samples = 4;
                    diam      = $urandom_range(1, 1 << 20);
                    speed     = $urandom;
                end
                7: begin n_samples = 3;  diam = $urandom;  speed = $urandom; end
                8: begin
                    n_samples = 20;
                    diam      = $urandom_range(1 << 12, 1 << 20);
                    speed     = $urandom_range(1, 1 << 17);
                end
                default: begin n_samples = 10; diam = $urandom; speed = '1; end
            endcase

            drain();
            write_reg(CFG_SERIES_LEN, WORD_W'(n_samples));
            write_reg(CFG_BODY_DIAMETER, diam);
            write_reg(CFG_FREE_STREAM_SPEED, speed);

            if (p < 3) begin
                tx_idle_pct  = 28;
                rx_idle_pct <= 84;
            end else if (p < 6) begin
                tx_idle_pct  = 84;
                rx_idle_pct <= 28;
            end else begin
                tx_idle_pct  = 0;
                rx_idle_pct <= 0;
            end

            // With four-sample series and a receiver that stops taking words
            // for a long stretch, the output register fills and the block has
            // to stall its sample input while the sender keeps offering.
            if (p == 6) holdoff_reqs <= holdoff_reqs + 1;

            // Mostly well-formed series; about one in five is noise.
            for (int s = 0; s < PHASE_SAMPLES / n_samples + 1; s++)
                run_series(n_samples, $urandom_range(0, 4) == 0);
        end

        drain();
        if (mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
